// ----- design/cfrd_pkg.sv -----
// package: types and constants of the crc frame resync decoder
package cfrd_pkg;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_PULL  = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [2:0] ST_NEED_MORE   = 3'd0;
  localparam logic [2:0] ST_READY       = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd5;
  localparam logic [2:0] ST_CRC_ERROR   = 3'd6;

  localparam logic [7:0]  MAGIC_B  = 8'h42;
  localparam logic [7:0]  MAGIC_C  = 8'h43;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int unsigned HDR_BYTES = 9;

  localparam logic [1:0] ADDR_VERSION = 2'd0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  msg_type;
    logic [7:0]  frame_flags;
    logic [15:0] sequence_number;
    logic [5:0]  payload_length;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last;
  } out_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- design/crc_frame_resync_decoder.sv -----
// top level: length prefixed frame decoder with crc check and resync
// A push goes through accept, memory write, result load, and a state with the
// result on the output. A pull walks the buffer through the single receive memory port,
// one byte a cycle in the magic search, header and crc pass. That pass over a good frame
// covers 9 + len + 2 bytes; a header result follows, then one result per payload byte,
// with a payload of up to 63 bytes. Reset, unused commands, overflow answers and pulls
// with fewer than two bytes answer with a single result.
// The result register holds one item; a new item is taken only after it is delivered.
module crc_frame_resync_decoder #(
  parameter int BUFFER_BYTES = 128,
  parameter int MAX_PAYLOAD  = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cfrd_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfrd_pkg::out_item_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_BYTES);
  localparam logic [CW-1:0] HDR_C   = CW'(cfrd_pkg::HDR_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PUSH = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_HDR  = 4'd3;
  localparam logic [3:0] S_CRC  = 4'd4;
  localparam logic [3:0] S_EMIT = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;
  localparam logic [3:0] S_WAIT = 4'd7;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] head_q, head_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    ver_q;
  logic [CW-1:0] off_q, off_d;     // offset of the byte presented at ram output
  logic          rd_q, rd_d;       // ram output holds byte at off_q
  logic [7:0]    prev_q, prev_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    type_q, type_d, flags_q, flags_d;
  logic [15:0]   seq_q, seq_d, len_q, len_d, want_q, want_d;
  logic [7:0]    wbyte_q, wbyte_d;
  logic [6:0]    k_q, k_d;
  logic          ov_q, ov_d;
  cfrd_pkg::out_item_t res_q, res_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    rdata;
  logic [CW-1:0] rd_off;
  logic          rd_en;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, o};
    if (s >= {1'b0, DEPTH_C}) s = s - {1'b0, DEPTH_C};
    return s[AW-1:0];
  endfunction

  cfrd_ram #(.Width(8), .Depth(BUFFER_BYTES)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wbyte_q), .rdata_o(rdata)
  );

  assign pready = 1'b1;
  assign prdata = {24'd0, ver_q};
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  always_comb begin
    cfrd_pkg::out_item_t r;
    logic [CW-1:0] flen;
    state_d = state_q; fill_d = fill_q; head_d = head_q; ovf_d = ovf_q;
    off_d = off_q; rd_d = 1'b0; prev_d = prev_q; crc_d = crc_q;
    type_d = type_q; flags_d = flags_q; seq_d = seq_q; len_d = len_q;
    want_d = want_q; wbyte_d = wbyte_q; k_d = k_q; ov_d = ov_q; res_d = res_q;
    we = 1'b0; rd_en = 1'b0; rd_off = off_q;
    r = '0; r.last = 1'b1;
    flen = len_q[CW-1:0] + HDR_C + CW'(2);
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.cmd)
            cfrd_pkg::CMD_PUSH: begin
              if (fill_q >= DEPTH_C) begin
                fill_d = '0; head_d = '0; ovf_d = 1'b1;
                r.status = cfrd_pkg::ST_OVERFLOW;
                res_d = r; state_d = S_OUT;
              end else begin
                wbyte_d = in_data_i.data_byte; state_d = S_PUSH;
              end
            end
            cfrd_pkg::CMD_PULL: begin
              if (ovf_q) begin
                ovf_d = 1'b0; r.status = cfrd_pkg::ST_OVERFLOW;
                res_d = r; state_d = S_OUT;
              end else if (fill_q < CW'(2)) begin
                res_d = r; state_d = S_OUT;
              end else begin
                rd_en = 1'b1; rd_off = '0; rd_d = 1'b1; off_d = '0;
                state_d = S_SCAN;
              end
            end
            cfrd_pkg::CMD_RESET: begin
              fill_d = '0; head_d = '0; ovf_d = 1'b0;
              res_d = r; state_d = S_OUT;
            end
            default: begin
              res_d = r; state_d = S_OUT;
            end
          endcase
        end
      end
      S_PUSH: begin
        we = 1'b1; rd_off = fill_q; fill_d = fill_q + CW'(1);
        res_d = r; state_d = S_OUT;
      end
      S_SCAN: begin
        // byte off_q on rdata; prev_q holds byte off_q-1
        if (rd_q && off_q != '0 && prev_q == cfrd_pkg::MAGIC_B
            && rdata == cfrd_pkg::MAGIC_C) begin
          if (off_q != CW'(1)) begin
            head_d = wrap(head_q, off_q - CW'(1));
            fill_d = fill_q - (off_q - CW'(1));
            r.status = cfrd_pkg::ST_BAD_MAGIC; res_d = r; state_d = S_OUT;
          end else if (fill_q < HDR_C) begin
            res_d = r; state_d = S_OUT;
          end else begin
            crc_d = cfrd_pkg::crc_byte(cfrd_pkg::crc_byte(cfrd_pkg::CRC_INIT,
                      cfrd_pkg::MAGIC_B), cfrd_pkg::MAGIC_C);
            rd_en = 1'b1; rd_off = CW'(2); off_d = CW'(2); rd_d = 1'b1;
            state_d = S_HDR;
          end
        end else if (rd_q && off_q + CW'(1) >= fill_q) begin
          head_d = wrap(head_q, fill_q - CW'(1));
          fill_d = CW'(1);
          r.status = cfrd_pkg::ST_BAD_MAGIC; res_d = r; state_d = S_OUT;
        end else if (rd_q) begin
          prev_d = rdata; rd_en = 1'b1; rd_off = off_q + CW'(1);
          off_d = off_q + CW'(1); rd_d = 1'b1;
        end
      end
      S_HDR: begin
        crc_d = cfrd_pkg::crc_byte(crc_q, rdata);
        case (off_q[3:0])
          4'd2: if (rdata != ver_q) begin
            head_d = wrap(head_q, CW'(2)); fill_d = fill_q - CW'(2);
            r.status = cfrd_pkg::ST_BAD_VERSION; res_d = r; state_d = S_OUT;
          end
          4'd3: type_d = rdata;
          4'd4: flags_d = rdata;
          4'd5: seq_d[7:0] = rdata;
          4'd6: seq_d[15:8] = rdata;
          4'd7: len_d[7:0] = rdata;
          default: len_d[15:8] = rdata;
        endcase
        if (state_d == S_HDR) begin
          if (off_q == CW'(8)) begin
            if ({rdata, len_q[7:0]} > 16'(MAX_PAYLOAD)) begin
              head_d = wrap(head_q, CW'(2)); fill_d = fill_q - CW'(2);
              r.status = cfrd_pkg::ST_TOO_LARGE; res_d = r; state_d = S_OUT;
            end else if (fill_q < CW'(len_q[5:0]) + HDR_C + CW'(2)) begin
              res_d = r; state_d = S_OUT;
            end else begin
              rd_en = 1'b1; rd_off = off_q + CW'(1); off_d = rd_off;
              state_d = S_CRC;
            end
          end else begin
            rd_en = 1'b1; rd_off = off_q + CW'(1); off_d = rd_off;
          end
        end
      end
      S_CRC: begin
        if (off_q < len_q[CW-1:0] + HDR_C) crc_d = cfrd_pkg::crc_byte(crc_q, rdata);
        else if (off_q == len_q[CW-1:0] + HDR_C) want_d[7:0] = rdata;
        else want_d[15:8] = rdata;
        if (off_q == flen - CW'(1)) begin
          if ({rdata, want_q[7:0]} != crc_q) begin
            head_d = wrap(head_q, CW'(2)); fill_d = fill_q - CW'(2);
            r.status = cfrd_pkg::ST_CRC_ERROR; res_d = r; state_d = S_OUT;
          end else begin
            r.status = cfrd_pkg::ST_READY; r.msg_type = type_q;
            r.frame_flags = flags_q; r.sequence_number = seq_q;
            r.payload_length = len_q[5:0]; r.last = (len_q == '0);
            res_d = r; k_d = '0; state_d = S_OUT;
          end
        end else begin
          rd_en = 1'b1; rd_off = off_q + CW'(1); off_d = rd_off;
        end
      end
      S_EMIT: begin
        r = res_q; r.payload_byte = rdata; r.byte_valid = 1'b1;
        r.last = (k_q == len_q[6:0]);
        res_d = r; state_d = S_OUT;
      end
      S_OUT: begin
        ov_d = 1'b1; state_d = S_WAIT;
      end
      default: begin
        if (!ov_q || !out_stall_i) begin
          if (res_q.last) begin
            if (res_q.status == cfrd_pkg::ST_READY) begin
              if (flen >= fill_q) begin
                fill_d = '0; head_d = '0;
              end else begin
                head_d = wrap(head_q, flen); fill_d = fill_q - flen;
              end
            end
            state_d = S_IDLE;
          end else begin
            k_d = k_q + 7'd1; rd_en = 1'b1;
            rd_off = HDR_C + {{(CW - 7){1'b0}}, k_q};
            state_d = S_EMIT;
          end
        end
      end
    endcase
    addr = wrap(head_q, rd_off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; fill_q <= '0; head_q <= '0; ovf_q <= 1'b0;
      ver_q <= 8'd1; ov_q <= 1'b0; rd_q <= 1'b0; off_q <= '0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; head_q <= head_d; ovf_q <= ovf_d;
      ov_q <= ov_d; rd_q <= rd_d | rd_en; off_q <= off_d;
      if (psel && penable && pwrite && paddr == cfrd_pkg::ADDR_VERSION) begin
        ver_q <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d; crc_q <= crc_d; type_q <= type_d; flags_q <= flags_d;
    seq_q <= seq_d; len_q <= len_d; want_q <= want_d; wbyte_q <= wbyte_d;
    k_q <= k_d; res_q <= res_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_C) else $error("fill count beyond buffer");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_ready_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.status == cfrd_pkg::ST_READY) |-> (len_q <= 16'(MAX_PAYLOAD)))
    else $error("oversized frame delivered");
endmodule

// ----- design/cfrd_ram.sv -----
// generic single port ram with registered read
module cfrd_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
